// ===== hdl/binary_min_heap_queue_core_defines.svh =====
// assertion macros for the heap queue checker
// bodies refer to i_clk and i_rst_n of the module that expands them
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BMHQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BMHQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bmhq_pkg.sv =====
// shared widths, codes, chain structs and helpers for the heap queue
// no dependencies; compiled before every other file
package bmhq_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_W        = 32;
    localparam int OP_W         = 2;
    localparam int ST_W         = 2;
    localparam int CNT_OUT_W    = 11;
    localparam int POS_W        = 17;
    localparam int LV_W         = 5;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // token walking down the level chain
    typedef struct packed {
        logic                    vld;
        logic                    del;
        logic signed [KEY_W-1:0] x;
        logic [POS_W-1:0]        node;
        logic [LV_W-1:0]         lvl;
        logic [POS_W-1:0]        cnt;
    } t_tok;

    // write-back travelling one level up
    typedef struct packed {
        logic                    en;
        logic                    last;
        logic [POS_W-1:0]        idx;
        logic signed [KEY_W-1:0] data;
    } t_wb;

    // direct read of the last element before a remove
    typedef struct packed {
        logic             en;
        logic [LV_W-1:0]  lvl;
        logic [POS_W-1:0] idx;
    } t_fetch;

    typedef struct packed {
        logic                    done;
        logic                    wr;
        logic signed [KEY_W-1:0] data;
    } t_cstat;

    function automatic logic [LV_W-1:0] floor_log2(input logic [POS_W-1:0] n);
        logic [LV_W-1:0] d;
        d = '0;
        for (int i = 0; i < POS_W; i++) begin
            if (n[i]) begin
                d = LV_W'(i);
            end
        end
        return d;
    endfunction

endpackage

// ===== hdl/bmhq_in_if.sv =====
// request channel of the heap queue: operation and key
// depends on bmhq_pkg
interface bmhq_in_if;
    import bmhq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic signed [KEY_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);

endinterface

// ===== hdl/bmhq_out_if.sv =====
// response channel of the heap queue: status, removed key, minimum, count
// depends on bmhq_pkg
interface bmhq_out_if;
    import bmhq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic signed [KEY_W-1:0] removed_value;
    logic signed [KEY_W-1:0] minimum_value;
    logic [CNT_OUT_W-1:0]    element_count;
    logic                    heap_empty;

    modport source (output valid, output status, output removed_value,
                    output minimum_value, output element_count, output heap_empty,
                    input ready);
    modport sink   (input valid, input status, input removed_value,
                    input minimum_value, input element_count, input heap_empty,
                    output ready);

endinterface

// ===== hdl/bmhq_level_cell.sv =====
// one heap level: its slice of the key store plus insert and sift-down steps
// depends on bmhq_pkg; chained by binary_min_heap_queue_core
module bmhq_level_cell #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF,
    parameter int LEVEL    = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bmhq_pkg::t_tok                   i_tok,
    output bmhq_pkg::t_tok                   o_tok,
    input  bmhq_pkg::t_wb                    i_wb,
    output bmhq_pkg::t_wb                    o_wb,
    input  bmhq_pkg::t_fetch                 i_fetch,
    output logic signed [bmhq_pkg::KEY_W-1:0] o_rd,
    output bmhq_pkg::t_cstat                 o_stat
);
    import bmhq_pkg::*;

    localparam int SPAN  = 1 << LEVEL;
    localparam int DEPTH = (SPAN < CAPACITY - SPAN + 1) ? SPAN : CAPACITY - SPAN + 1;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [POS_W-1:0] LVL_MASK  = POS_W'(SPAN - 1);
    localparam logic [POS_W-1:0] FIRST_POS = POS_W'(SPAN - 1);
    localparam logic [LV_W-1:0]  MY_LVL    = LV_W'(LEVEL);

    logic signed [KEY_W-1:0] r_mem [DEPTH];
    logic signed [KEY_W-1:0] r_rd_a;
    logic signed [KEY_W-1:0] r_rd_b;

    t_tok             r_hold;
    logic             r_act;
    logic [IW-1:0]    r_ia;
    logic [POS_W-1:0] r_c0;
    logic             r_e0;
    logic             r_e1;

    t_tok r_tok_out;
    t_tok n_tok_out;
    t_wb  r_wb_out;
    t_wb  n_wb_out;
    logic r_done;
    logic n_done;

    logic             tok_act;
    logic             ins_here;
    logic [POS_W-1:0] anc;
    logic [IW-1:0]    ins_idx;
    logic [POS_W-1:0] c0;
    logic [POS_W-1:0] pos0;
    logic             e0;
    logic             e1;
    logic [IW-1:0]    ra_addr;
    logic [IW-1:0]    rb_addr;

    logic                    keep_x;
    logic                    pick1;
    logic signed [KEY_W-1:0] vp;
    logic [POS_W-1:0]        cp;
    logic [POS_W-1:0]        cpg;
    logic [POS_W-1:0]        leftg;
    logic                    go_down;
    logic                    leaf;

    logic                    we;
    logic [IW-1:0]           wa;
    logic signed [KEY_W-1:0] wd;

    // arrival side
    always_comb begin
        tok_act  = i_tok.vld && !(i_tok.del && (LEVEL == 0));
        ins_here = i_tok.vld && !i_tok.del && (i_tok.lvl == MY_LVL);
        anc      = i_tok.node >> (i_tok.lvl - MY_LVL);
        ins_idx  = IW'(anc & LVL_MASK);
        c0       = POS_W'(i_tok.node << 1);
        pos0     = FIRST_POS + c0;
        e0       = pos0 < i_tok.cnt;
        e1       = (pos0 + 1'b1) < i_tok.cnt;
        if (i_fetch.en && (i_fetch.lvl == MY_LVL)) begin
            ra_addr = IW'(i_fetch.idx & LVL_MASK);
        end else if (i_tok.del) begin
            ra_addr = IW'(c0);
        end else begin
            ra_addr = ins_idx;
        end
        rb_addr = IW'(c0 | POS_W'(1));
    end

    // compare side, right child wins a tie
    always_comb begin
        keep_x  = $signed(r_hold.x) < r_rd_a;
        pick1   = r_e1 && !(r_rd_a < r_rd_b);
        vp      = pick1 ? r_rd_b : r_rd_a;
        cp      = pick1 ? (r_c0 | POS_W'(1)) : r_c0;
        go_down = r_e0 && !($signed(r_hold.x) < vp);
        cpg     = FIRST_POS + cp;
        leftg   = POS_W'((cpg << 1) + POS_W'(1));
        leaf    = !(leftg < r_hold.cnt);
    end

    always_comb begin
        n_tok_out     = i_tok;
        n_tok_out.vld = 1'b0;
        n_wb_out.en   = 1'b0;
        n_wb_out.last = 1'b0;
        n_wb_out.idx  = r_hold.node;
        n_wb_out.data = r_hold.x;
        we            = 1'b0;
        wa            = ins_idx;
        wd            = i_tok.x;
        n_done        = 1'b0;

        if (i_tok.vld && i_tok.del && (LEVEL == 0)) begin
            n_tok_out.vld = 1'b1;
        end
        if (ins_here) begin
            we     = 1'b1;
            n_done = 1'b1;
        end
        if (i_wb.en) begin
            we     = 1'b1;
            wa     = IW'(i_wb.idx);
            wd     = i_wb.data;
            n_done = i_wb.last;
        end
        if (r_act) begin
            n_tok_out = r_hold;
            if (r_hold.del) begin
                n_wb_out.en   = 1'b1;
                n_wb_out.last = !go_down;
                n_wb_out.data = go_down ? vp : r_hold.x;
                n_tok_out.node = cp;
                n_tok_out.vld  = go_down && !leaf;
                if (go_down && leaf) begin
                    we     = 1'b1;
                    wa     = IW'(cp);
                    wd     = r_hold.x;
                    n_done = 1'b1;
                end
            end else begin
                n_tok_out.x   = keep_x ? r_rd_a : r_hold.x;
                n_tok_out.vld = 1'b1;
                we            = 1'b1;
                wa            = r_ia;
                wd            = keep_x ? r_hold.x : r_rd_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        r_rd_a <= r_mem[ra_addr];
        r_rd_b <= r_mem[rb_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act         <= 1'b0;
            r_tok_out.vld <= 1'b0;
            r_wb_out.en   <= 1'b0;
            r_done        <= 1'b0;
        end else begin
            r_act     <= tok_act && !ins_here;
            r_tok_out <= n_tok_out;
            r_wb_out  <= n_wb_out;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tok_act && !ins_here) begin
            r_hold <= i_tok;
            r_ia   <= ins_idx;
            r_c0   <= c0;
            r_e0   <= e0;
            r_e1   <= e1;
        end
    end

    assign o_tok       = r_tok_out;
    assign o_wb        = r_wb_out;
    assign o_rd        = r_rd_a;
    assign o_stat.done = r_done;
    assign o_stat.wr   = we;
    assign o_stat.data = wd;

endmodule

// ===== hdl/binary_min_heap_queue_core.sv =====
// binary min-heap priority queue: sequencer over a chain of heap level cells
// depends on bmhq_pkg, bmhq_in_if, bmhq_out_if, bmhq_level_cell
//
//  port    dir  carries                                              accepted when
//  i_req   in   operation, value                                     valid && ready
//  o_rsp   out  status, removed_value, minimum_value, count, empty   valid && ready
//
// insert: the token walks down the chain of level cells to the level of the new node
// remove: the last element is read from its level, loaded as the root token and sifted down
// clear, reject, last-element remove and no-op go straight to the result state
// reset clears the count and the control state; the level memories need no clearing pass
// one request in flight; the next is taken while a response waits in the output register
module binary_min_heap_queue_core #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bmhq_in_if.sink   i_req,
    bmhq_out_if.source o_rsp
);
    import bmhq_pkg::*;

    localparam int NL = $clog2(CAPACITY + 1);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = $clog2(NL);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FETCH  = 3'd1;
    localparam logic [2:0] S_LOAD   = 3'd2;
    localparam logic [2:0] S_WAIT   = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0]              r_state;
    logic [CW-1:0]           r_cnt;
    logic signed [KEY_W-1:0] r_min;
    logic [ST_W-1:0]         r_status;
    logic signed [KEY_W-1:0] r_removed;
    logic [LV_W-1:0]         r_flvl;
    t_tok                    r_tok;
    t_fetch                  r_fetch;

    logic                    r_ov;
    logic [ST_W-1:0]         r_o_status;
    logic signed [KEY_W-1:0] r_o_removed;
    logic signed [KEY_W-1:0] r_o_min;
    logic [CNT_OUT_W-1:0]    r_o_count;
    logic                    r_o_empty;

    t_tok                    tok_chain [NL+1];
    t_wb                     wb_chain  [NL+1];
    t_cstat                  stat_vec  [NL];
    logic signed [KEY_W-1:0] rd_vec    [NL];
    logic [NL-1:0]           done_vec;

    logic             req_acc;
    logic [POS_W-1:0] ins_node;
    logic [POS_W-1:0] last_node;
    logic [LV_W-1:0]  ins_lvl;
    logic [LV_W-1:0]  last_lvl;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign ins_node    = POS_W'(r_cnt) + POS_W'(1);
    assign last_node   = POS_W'(r_cnt);
    assign ins_lvl     = floor_log2(ins_node);
    assign last_lvl    = floor_log2(last_node);

    assign tok_chain[0] = r_tok;
    assign wb_chain[NL] = '0;

    for (genvar k = 0; k < NL; k++) begin : g_lvl
        bmhq_level_cell #(
            .CAPACITY (CAPACITY),
            .LEVEL    (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (tok_chain[k]),
            .o_tok   (tok_chain[k+1]),
            .i_wb    (wb_chain[k+1]),
            .o_wb    (wb_chain[k]),
            .i_fetch (r_fetch),
            .o_rd    (rd_vec[k]),
            .o_stat  (stat_vec[k])
        );
        assign done_vec[k] = stat_vec[k].done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_tok.vld  <= 1'b0;
            r_fetch.en <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_tok.vld  <= 1'b0;
            r_fetch.en <= 1'b0;
            if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            // root slot mirror
            if (stat_vec[0].wr) begin
                r_min <= stat_vec[0].data;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_status  <= ST_DONE;
                        r_removed <= '0;
                        case (i_req.operation)
                            OP_INSERT: begin
                                if (r_cnt >= CAP_CNT) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_RESULT;
                                end else begin
                                    r_tok.vld  <= 1'b1;
                                    r_tok.del  <= 1'b0;
                                    r_tok.x    <= i_req.value;
                                    r_tok.node <= ins_node;
                                    r_tok.lvl  <= ins_lvl;
                                    r_tok.cnt  <= ins_node;
                                    r_cnt      <= r_cnt + 1'b1;
                                    r_state    <= S_WAIT;
                                end
                            end
                            OP_REMOVE: begin
                                if (r_cnt == '0) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_RESULT;
                                end else begin
                                    r_removed <= r_min;
                                    r_cnt     <= r_cnt - 1'b1;
                                    if (r_cnt == CW'(1)) begin
                                        r_state <= S_RESULT;
                                    end else begin
                                        r_fetch.en  <= 1'b1;
                                        r_fetch.lvl <= last_lvl;
                                        r_fetch.idx <= last_node;
                                        r_flvl      <= last_lvl;
                                        r_state     <= S_FETCH;
                                    end
                                end
                            end
                            OP_CLEAR: begin
                                r_cnt   <= '0;
                                r_state <= S_RESULT;
                            end
                            default: begin
                                r_state <= S_RESULT;
                            end
                        endcase
                    end
                end
                S_FETCH: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    // last element becomes the root and sinks
                    r_tok.vld  <= 1'b1;
                    r_tok.del  <= 1'b1;
                    r_tok.x    <= rd_vec[r_flvl[SW-1:0]];
                    r_tok.node <= '0;
                    r_tok.lvl  <= r_flvl;
                    r_tok.cnt  <= POS_W'(r_cnt);
                    r_state    <= S_WAIT;
                end
                S_WAIT: begin
                    if (|done_vec) begin
                        r_state <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_ov        <= 1'b1;
                        r_o_status  <= r_status;
                        r_o_removed <= r_removed;
                        r_o_min     <= (r_cnt == '0) ? '0 : r_min;
                        r_o_count   <= CNT_OUT_W'(r_cnt);
                        r_o_empty   <= (r_cnt == '0);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.removed_value = r_o_removed;
    assign o_rsp.minimum_value = r_o_min;
    assign o_rsp.element_count = r_o_count;
    assign o_rsp.heap_empty    = r_o_empty;

endmodule

// ===== hdl/bmhq_checker.sv =====
// response-side checks for the heap queue, bound to the top level
// depends on bmhq_pkg and binary_min_heap_queue_core_defines.svh
`include "binary_min_heap_queue_core_defines.svh"

module bmhq_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [bmhq_pkg::ST_W-1:0]        i_status,
    input logic signed [bmhq_pkg::KEY_W-1:0] i_removed,
    input logic signed [bmhq_pkg::KEY_W-1:0] i_minimum,
    input logic [bmhq_pkg::CNT_OUT_W-1:0]   i_count,
    input logic                             i_empty
);
    import bmhq_pkg::*;

    `BMHQ_ASSERT_IMP(a_empty_flag, i_out_valid, i_empty == (i_count == '0), "empty flag vs count")
    `BMHQ_ASSERT_IMP(a_min_zero, i_out_valid && i_empty, i_minimum == '0, "minimum not zero")
    `BMHQ_ASSERT_IMP(a_rm_zero, i_out_valid && (i_status != ST_DONE), i_removed == '0, "removed set")
    `BMHQ_ASSERT_IMP(a_rm_empty, i_out_valid && (i_status == ST_EMPTY), i_empty, "empty remove")
    `BMHQ_ASSERT_NXT(a_rsp_hold, i_out_valid && !i_out_ready, i_out_valid, "response dropped")

endmodule

bind binary_min_heap_queue_core bmhq_checker u_bmhq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_removed   (o_rsp.removed_value),
    .i_minimum   (o_rsp.minimum_value),
    .i_count     (o_rsp.element_count),
    .i_empty     (o_rsp.heap_empty)
);

// ===== sim/binary_min_heap_queue_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for binary_min_heap_queue_core: directed, random and fill tests
// depends on bmhq_pkg, bmhq_in_if, bmhq_out_if and core; one shadow heap updated per request
module binary_min_heap_queue_core_tb;
    import bmhq_pkg::*;

    localparam int HEAP_DEPTH              = CAPACITY_DEF;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
    localparam int SETTLE_CYCLES           = 40;
    localparam int LIMIT_CYCLES            = 400_000;

    typedef struct {
        logic [ST_W-1:0]         status;
        logic signed [KEY_W-1:0] removed;
        logic signed [KEY_W-1:0] minimum;
        logic [CNT_OUT_W-1:0]    count;
        logic                    empty;
    } heap_result_t;

    logic clk;
    logic rst_n;

    bmhq_in_if  req_if ();
    bmhq_out_if rsp_if ();

    logic signed [KEY_W-1:0] shadow_heap [HEAP_DEPTH];
    int unsigned             shadow_fill;
    heap_result_t            pending_results [$];
    int                      fail_count     = 0;
    int                      send_gap_pct   = 0;
    int                      recv_stall_pct = 0;

    binary_min_heap_queue_core #(
        .CAPACITY(HEAP_DEPTH)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #(LIMIT_CYCLES * 12);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic heap_result_t apply_heap_op(input logic [OP_W-1:0] op,
                                                   input logic signed [KEY_W-1:0] key);
        heap_result_t            res;
        logic signed [KEY_W-1:0] tmp;
        int unsigned             pos;
        int unsigned             up;
        int unsigned             lc;
        int unsigned             pick;
        res.status  = ST_DONE;
        res.removed = '0;
        case (op)
            OP_INSERT: begin
                if (shadow_fill >= HEAP_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    pos = shadow_fill;
                    shadow_heap[pos] = key;
                    shadow_fill++;
                    while (pos > 0) begin
                        up = (pos - 1) / 2;
                        if (!(shadow_heap[pos] < shadow_heap[up])) break;
                        tmp              = shadow_heap[pos];
                        shadow_heap[pos] = shadow_heap[up];
                        shadow_heap[up]  = tmp;
                        pos = up;
                    end
                end
            end
            OP_REMOVE: begin
                if (shadow_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.removed = shadow_heap[0];
                    shadow_fill--;
                    shadow_heap[0] = shadow_heap[shadow_fill];
                    pos = 0;
                    forever begin
                        lc = 2 * pos + 1;
                        if (lc >= shadow_fill) break;
                        pick = lc;
                        // right child wins a tie
                        if (lc + 1 < shadow_fill && !(shadow_heap[lc] < shadow_heap[lc + 1]))
                            pick = lc + 1;
                        if (shadow_heap[pos] < shadow_heap[pick]) break;
                        tmp               = shadow_heap[pos];
                        shadow_heap[pos]  = shadow_heap[pick];
                        shadow_heap[pick] = tmp;
                        pos = pick;
                    end
                end
            end
            OP_CLEAR: begin
                shadow_fill = 0;
            end
            default: begin
            end
        endcase
        res.minimum = (shadow_fill != 0) ? shadow_heap[0] : '0;
        res.count   = CNT_OUT_W'(shadow_fill);
        res.empty   = (shadow_fill == 0);
        return res;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        int v;
        case ($urandom_range(3))
            0: begin
                // narrow range so equal keys meet in the heap
                v = int'($urandom_range(7)) - 4;
                return v;
            end
            1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic signed [KEY_W-1:0] key);
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.value     <= key;
        do @(posedge clk); while (!req_if.ready);
        pending_results.push_back(apply_heap_op(op, key));
    endtask

    task automatic drain_responses(input int settle);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic test_directed();
        send_request(OP_UNUSED, 32'sh1234_5678);
        send_request(OP_REMOVE, '0);
        send_request(OP_INSERT, 32'sh7FFF_FFFF);
        send_request(OP_INSERT, 32'sh8000_0000);
        send_request(OP_INSERT, 32'sh0000_0000);
        send_request(OP_INSERT, -32'sd1);
        send_request(OP_INSERT, 32'sd1);
        send_request(OP_INSERT, -32'sd1);
        send_request(OP_UNUSED, 32'shFFFF_FFFF);
        send_request(OP_REMOVE, 32'shFFFF_FFFF);
        send_request(OP_REMOVE, '0);
        send_request(OP_REMOVE, '0);
        send_request(OP_REMOVE, '0);
        send_request(OP_CLEAR, 32'sh5555_5555);
        send_request(OP_REMOVE, '0);
        send_request(OP_INSERT, 32'sd5);
        send_request(OP_INSERT, 32'sd5);
        send_request(OP_INSERT, 32'sd5);
        send_request(OP_INSERT, 32'sd4);
        send_request(OP_REMOVE, '0);
        send_request(OP_REMOVE, '0);
        send_request(OP_REMOVE, '0);
        send_request(OP_CLEAR, 32'shAAAA_AAAA);
    endtask

    task automatic test_random_mix(input int count);
        int               roll;
        logic [OP_W-1:0]  op;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < 52)      op = OP_INSERT;
            else if (roll < 92) op = OP_REMOVE;
            else if (roll < 96) op = OP_CLEAR;
            else                op = OP_UNUSED;
            send_request(op, pick_key());
        end
    endtask

    task automatic test_fill_to_capacity();
        send_request(OP_CLEAR, $urandom);
        for (int i = 0; i < HEAP_DEPTH; i++) begin
            send_request(OP_INSERT, pick_key());
        end
        send_request(OP_INSERT, 32'sh8000_0000);
        send_request(OP_INSERT, 32'sh7FFF_FFFF);
        send_request(OP_UNUSED, $urandom);
        for (int i = 0; i < 8; i++) begin
            send_request(OP_REMOVE, $urandom);
        end
        send_request(OP_INSERT, pick_key());
        send_request(OP_CLEAR, $urandom);
    endtask

    // response ready with random stalls
    always @(posedge clk) begin
        rsp_if.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        heap_result_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("response with no request outstanding");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                    fail_count++;
                end
                if (rsp_if.removed_value !== want.removed) begin
                    $error("removed_value: expected %0d, got %0d",
                           want.removed, rsp_if.removed_value);
                    fail_count++;
                end
                if (rsp_if.minimum_value !== want.minimum) begin
                    $error("minimum_value: expected %0d, got %0d",
                           want.minimum, rsp_if.minimum_value);
                    fail_count++;
                end
                if (rsp_if.element_count !== want.count) begin
                    $error("element_count: expected %0d, got %0d",
                           want.count, rsp_if.element_count);
                    fail_count++;
                end
                if (rsp_if.heap_empty !== want.empty) begin
                    $error("heap_empty: expected %0d, got %0d", want.empty, rsp_if.heap_empty);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        rst_n            <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.operation <= OP_INSERT;
        req_if.value     <= '0;
        shadow_fill       = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        send_gap_pct   = 8;
        recv_stall_pct = 51;
        test_directed();
        test_random_mix(20);
        drain_responses(4);

        send_gap_pct   = 51;
        recv_stall_pct = 8;
        test_random_mix(20);
        drain_responses(4);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_fill_to_capacity();

        drain_responses(SETTLE_CYCLES);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
